// ===== hdl/nic_descriptor_ring_engine_defines.svh =====
// Assertion macros shared by the descriptor ring engine RTL.
`ifndef NIC_DESCRIPTOR_RING_ENGINE_DEFINES_SVH
`define NIC_DESCRIPTOR_RING_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NDRE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("descriptor ring engine: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NDRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("descriptor ring engine: check failed");

`endif

// ===== hdl/ndre_pkg.sv =====
// Types, codes and constants of the descriptor ring engine.
`timescale 1ns / 1ps
package ndre_pkg;

    localparam int TX_SLOTS_DEF = 32;
    localparam int RX_SLOTS_DEF = 32;

    localparam int LEN_W    = 14;
    localparam int SLOT_W   = 6;
    localparam int FREE_W   = 7;
    localparam int REQ_W    = 2;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;
    localparam int REGIDX_W = 2;

    // Register reset values
    localparam logic [LEN_W-1:0] MAX_SEND_RST = 14'd1518;
    localparam logic [LEN_W-1:0] MIN_RECV_RST = 14'd14;
    localparam logic [LEN_W-1:0] BUF_SIZE_RST = 14'd2048;

    // Register indexes
    localparam logic [REGIDX_W-1:0] REG_ENABLED  = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_MAX_SEND = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_MIN_RECV = 2'd2;
    localparam logic [REGIDX_W-1:0] REG_BUF_SIZE = 2'd3;

    // Request types
    localparam logic [REQ_W-1:0] REQ_SEND    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FILL    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_IRQ     = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RX   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIN  = 2'd2;

    // Send status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_INACTIVE = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic load_in;
        logic emit_send;
        logic free_tx;
        logic fill_rx;
        logic reclaim;
        logic emit_rx;
        logic emit_fin;
    } t_dp_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             tx_event;
        logic             rx_event;
        logic             reclaim_done;
        logic             rx_empty;
        logic             out_free;
    } t_dp_sts;

endpackage

// ===== hdl/ndre_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ndre_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/ndre_ctrl.sv =====
// Sequencer of the descriptor ring engine.
`timescale 1ns / 1ps
module ndre_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ndre_pkg::t_dp_sts i_sts,
    output ndre_pkg::t_dp_cmd o_cmd
);
    import ndre_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_RECLAIM = 3'd2;
    localparam logic [2:0] S_RX_CHK  = 3'd3;
    localparam logic [2:0] S_RX_EMIT = 3'd4;
    localparam logic [2:0] S_FIN     = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.req_type)
                    REQ_SEND: begin
                        if (i_sts.out_free) begin
                            cmd.emit_send = 1'b1;
                            n_state       = S_IDLE;
                        end
                    end
                    REQ_RELEASE: begin
                        cmd.free_tx = 1'b1;
                        n_state     = S_IDLE;
                    end
                    REQ_FILL: begin
                        cmd.fill_rx = 1'b1;
                        n_state     = S_IDLE;
                    end
                    default: begin
                        if (i_sts.tx_event) begin
                            n_state = S_RECLAIM;
                        end else if (i_sts.rx_event) begin
                            n_state = S_RX_CHK;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                endcase
            end
            S_RECLAIM: begin
                if (i_sts.reclaim_done) begin
                    n_state = i_sts.rx_event ? S_RX_CHK : S_FIN;
                end else begin
                    cmd.reclaim = 1'b1;
                end
            end
            S_RX_CHK: begin
                // ring read data for the current slot lands next cycle
                n_state = i_sts.rx_empty ? S_FIN : S_RX_EMIT;
            end
            S_RX_EMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit_rx = 1'b1;
                    n_state     = S_RX_CHK;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    cmd.emit_fin = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;
endmodule

// ===== hdl/ndre_dp.sv =====
// Datapath: registers, ring ownership state, fill length RAM and result register.
`timescale 1ns / 1ps
module ndre_dp #(
    parameter int TX_SLOTS = ndre_pkg::TX_SLOTS_DEF,
    parameter int RX_SLOTS = ndre_pkg::RX_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ndre_pkg::ADDR_W-1:0]   paddr,
    input  logic [ndre_pkg::DATA_W-1:0]   pwdata,
    output logic [ndre_pkg::DATA_W-1:0]   prdata,
    input  ndre_pkg::t_dp_cmd             i_cmd,
    output ndre_pkg::t_dp_sts             o_sts,
    input  logic [ndre_pkg::REQ_W-1:0]    i_req_type,
    input  logic [ndre_pkg::LEN_W-1:0]    i_frame_length,
    input  logic [ndre_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic                          i_tx_event,
    input  logic                          i_rx_event,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [ndre_pkg::KIND_W-1:0]   o_result_kind,
    output logic [ndre_pkg::STAT_W-1:0]   o_status,
    output logic [ndre_pkg::SLOT_W-1:0]   o_ring_slot,
    output logic [ndre_pkg::LEN_W-1:0]    o_slot_length,
    output logic                          o_deliver,
    output logic                          o_end_of_ring,
    output logic                          o_doorbell,
    output logic [ndre_pkg::FREE_W-1:0]   o_free_count,
    output logic                          o_last
);
    import ndre_pkg::*;

    localparam int TX_IDX_W = $clog2(TX_SLOTS);
    localparam int RX_IDX_W = $clog2(RX_SLOTS);
    localparam int CNT_W    = $clog2(TX_SLOTS + 1);

    // configuration
    logic             r_enabled;
    logic [LEN_W-1:0] r_max_send;
    logic [LEN_W-1:0] r_min_recv;
    logic [LEN_W-1:0] r_buf_size;
    logic             cfg_wr;
    logic [REGIDX_W-1:0] cfg_idx;

    // held input word
    logic [REQ_W-1:0]  r_req;
    logic [LEN_W-1:0]  r_len;
    logic [SLOT_W-1:0] r_slot;
    logic              r_txe;
    logic              r_rxe;

    // ring state
    logic [TX_SLOTS-1:0] r_tx_own;
    logic [RX_SLOTS-1:0] r_rx_own;
    logic [TX_IDX_W-1:0] r_tx_next;
    logic [TX_IDX_W-1:0] r_tx_reap;
    logic [CNT_W-1:0]    r_tx_free;
    logic [RX_IDX_W-1:0] r_rx_next;

    // result register
    logic                r_out_valid;
    logic [KIND_W-1:0]   r_kind;
    logic [STAT_W-1:0]   r_stat;
    logic [SLOT_W-1:0]   r_ring_slot;
    logic [LEN_W-1:0]    r_slot_len;
    logic                r_deliver;
    logic                r_eor;
    logic                r_bell;
    logic [FREE_W-1:0]   r_free_cnt;
    logic                r_last;

    logic                tx_slot_ok;
    logic                rx_slot_ok;
    logic [STAT_W-1:0]   send_stat;
    logic                send_ok;
    logic [TX_IDX_W-1:0] tx_next_inc;
    logic [TX_IDX_W-1:0] tx_reap_inc;
    logic [RX_IDX_W-1:0] rx_next_inc;
    logic [LEN_W-1:0]    rx_len;
    logic                rx_in_range;
    logic                ram_we;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_max_send <= MAX_SEND_RST;
            r_min_recv <= MIN_RECV_RST;
            r_buf_size <= BUF_SIZE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENABLED:  r_enabled  <= pwdata[0];
                REG_MAX_SEND: r_max_send <= pwdata[LEN_W-1:0];
                REG_MIN_RECV: r_min_recv <= pwdata[LEN_W-1:0];
                REG_BUF_SIZE: r_buf_size <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ENABLED:  prdata = DATA_W'(r_enabled);
            REG_MAX_SEND: prdata = DATA_W'(r_max_send);
            REG_MIN_RECV: prdata = DATA_W'(r_min_recv);
            REG_BUF_SIZE: prdata = DATA_W'(r_buf_size);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req  <= i_req_type;
            r_len  <= i_frame_length;
            r_slot <= i_slot_index;
            r_txe  <= i_tx_event;
            r_rxe  <= i_rx_event;
        end
    end

    assign tx_slot_ok = ({1'b0, r_slot} < (SLOT_W + 1)'(TX_SLOTS));
    assign rx_slot_ok = ({1'b0, r_slot} < (SLOT_W + 1)'(RX_SLOTS));

    // send checks in priority order: enable, length, free slot
    always_comb begin
        if (!r_enabled) begin
            send_stat = ST_INACTIVE;
        end else if (r_len > r_max_send) begin
            send_stat = ST_TOO_LONG;
        end else if (r_tx_free == '0) begin
            send_stat = ST_FULL;
        end else begin
            send_stat = ST_OK;
        end
    end
    assign send_ok = (send_stat == ST_OK);

    assign tx_next_inc  = (r_tx_next == TX_IDX_W'(TX_SLOTS - 1)) ? '0 : r_tx_next + 1'b1;
    assign tx_reap_inc  = (r_tx_reap == TX_IDX_W'(TX_SLOTS - 1)) ? '0 : r_tx_reap + 1'b1;
    assign rx_next_inc  = (r_rx_next == RX_IDX_W'(RX_SLOTS - 1)) ? '0 : r_rx_next + 1'b1;

    // Only fills write lengths: a drained slot is re-armed and can be read again
    // only after a fresh fill, so the drain write-back is never observed.
    assign ram_we = i_cmd.fill_rx && rx_slot_ok;

    ndre_ram #(
        .WIDTH (LEN_W),
        .DEPTH (RX_SLOTS)
    ) u_fill_len (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot[RX_IDX_W-1:0]),
        .i_wdata (r_len),
        .i_raddr (r_rx_next),
        .o_rdata (rx_len)
    );

    assign rx_in_range = (rx_len >= r_min_recv) && (rx_len <= r_buf_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_own    <= '0;
            r_rx_own    <= '1;
            r_tx_next   <= '0;
            r_tx_reap   <= '0;
            r_tx_free   <= CNT_W'(TX_SLOTS);
            r_rx_next   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit_send && send_ok) begin
                r_tx_own[r_tx_next] <= 1'b1;
                r_tx_free           <= r_tx_free - 1'b1;
                r_tx_next           <= tx_next_inc;
            end
            if (i_cmd.free_tx && tx_slot_ok) begin
                r_tx_own[r_slot[TX_IDX_W-1:0]] <= 1'b0;
            end
            if (i_cmd.reclaim) begin
                r_tx_free <= r_tx_free + 1'b1;
                r_tx_reap <= tx_reap_inc;
            end
            if (ram_we) begin
                r_rx_own[r_slot[RX_IDX_W-1:0]] <= 1'b0;
            end
            if (i_cmd.emit_rx) begin
                r_rx_own[r_rx_next] <= 1'b1;
                r_rx_next           <= rx_next_inc;
            end
            if (i_cmd.emit_send || i_cmd.emit_rx || i_cmd.emit_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_send) begin
            r_kind      <= KIND_SEND;
            r_stat      <= send_stat;
            r_ring_slot <= send_ok ? SLOT_W'(r_tx_next) : '0;
            r_slot_len  <= send_ok ? r_len : '0;
            r_deliver   <= 1'b0;
            r_eor       <= send_ok && (r_tx_next == TX_IDX_W'(TX_SLOTS - 1));
            r_bell      <= send_ok;
            r_free_cnt  <= send_ok ? FREE_W'(r_tx_free - 1'b1) : FREE_W'(r_tx_free);
            r_last      <= 1'b1;
        end else if (i_cmd.emit_rx) begin
            r_kind      <= KIND_RX;
            r_stat      <= ST_OK;
            r_ring_slot <= SLOT_W'(r_rx_next);
            r_slot_len  <= rx_len;
            r_deliver   <= rx_in_range;
            r_eor       <= (r_rx_next == RX_IDX_W'(RX_SLOTS - 1));
            r_bell      <= 1'b0;
            r_free_cnt  <= FREE_W'(r_tx_free);
            r_last      <= 1'b0;
        end else if (i_cmd.emit_fin) begin
            r_kind      <= KIND_FIN;
            r_stat      <= ST_OK;
            r_ring_slot <= '0;
            r_slot_len  <= '0;
            r_deliver   <= 1'b0;
            r_eor       <= 1'b0;
            r_bell      <= 1'b0;
            r_free_cnt  <= FREE_W'(r_tx_free);
            r_last      <= 1'b1;
        end
    end

    assign o_sts.req_type     = r_req;
    assign o_sts.tx_event     = r_txe;
    assign o_sts.rx_event     = r_rxe;
    assign o_sts.reclaim_done = (r_tx_free == CNT_W'(TX_SLOTS)) || r_tx_own[r_tx_reap];
    assign o_sts.rx_empty     = r_rx_own[r_rx_next];
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_status      = r_stat;
    assign o_ring_slot   = r_ring_slot;
    assign o_slot_length = r_slot_len;
    assign o_deliver     = r_deliver;
    assign o_end_of_ring = r_eor;
    assign o_doorbell    = r_bell;
    assign o_free_count  = r_free_cnt;
    assign o_last        = r_last;
endmodule

// ===== hdl/nic_descriptor_ring_engine.sv =====
// Top level of the transmit and receive descriptor ring ownership engine.
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one request word: a send, a
//   hardware release of a transmit slot, a hardware fill of a receive slot, or
//   an interrupt. Output channel (o_out_valid / i_out_ready) returns result
//   words; o_last marks the final word caused by a request.
//   Sends, releases and fills are taken, then executed; a send waits while
//   the result register is held. A send yields one result word; releases
//   and fills yield none. An interrupt is taken and executed; with tx_event
//   set it reclaims transmit slots one at a time, then ends the reclaim; with
//   rx_event set it drains receive slots in check and emit steps (registered
//   fill length RAM read) up to an empty check; then emits the closing word.
//   The next request is taken as soon as the previous one has left its last
//   word in the result register, so it overlaps the wait for the receiver.
//   A stalled receiver holds the result register and pauses the sequencer on
//   its next result; nothing is dropped.
//   Reset clears the ownership bits (transmit host-owned, receive armed),
//   ring pointers and registers to defaults; no clearing pass is needed. The
//   user must write registers over APB only while idle; it is not enforced.
`timescale 1ns / 1ps
`include "nic_descriptor_ring_engine_defines.svh"
module nic_descriptor_ring_engine #(
    parameter int TX_SLOTS = ndre_pkg::TX_SLOTS_DEF,
    parameter int RX_SLOTS = ndre_pkg::RX_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request words
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ndre_pkg::REQ_W-1:0]    i_req_type,
    input  logic [ndre_pkg::LEN_W-1:0]    i_frame_length,
    input  logic [ndre_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic                          i_tx_event,
    input  logic                          i_rx_event,
    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ndre_pkg::KIND_W-1:0]   o_result_kind,
    output logic [ndre_pkg::STAT_W-1:0]   o_status,
    output logic [ndre_pkg::SLOT_W-1:0]   o_ring_slot,
    output logic [ndre_pkg::LEN_W-1:0]    o_slot_length,
    output logic                          o_deliver,
    output logic                          o_end_of_ring,
    output logic                          o_doorbell,
    output logic [ndre_pkg::FREE_W-1:0]   o_free_count,
    output logic                          o_last,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ndre_pkg::ADDR_W-1:0]   paddr,
    input  logic [ndre_pkg::DATA_W-1:0]   pwdata,
    output logic [ndre_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import ndre_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // register accesses complete without wait states
    assign pready = 1'b1;

    // sequencer: walks each request through execute, reclaim and drain steps
    ndre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // datapath: holds the word, the rings, the registers and the result
    ndre_dp #(
        .TX_SLOTS (TX_SLOTS),
        .RX_SLOTS (RX_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_req_type     (i_req_type),
        .i_frame_length (i_frame_length),
        .i_slot_index   (i_slot_index),
        .i_tx_event     (i_tx_event),
        .i_rx_event     (i_rx_event),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_result_kind  (o_result_kind),
        .o_status       (o_status),
        .o_ring_slot    (o_ring_slot),
        .o_slot_length  (o_slot_length),
        .o_deliver      (o_deliver),
        .o_end_of_ring  (o_end_of_ring),
        .o_doorbell     (o_doorbell),
        .o_free_count   (o_free_count),
        .o_last         (o_last)
    );

    // a taken word keeps the sequencer busy in the next cycle
    `NDRE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // the free count never exceeds the ring size
    `NDRE_ASSERT_NOW(a_free_bound, i_clk, i_rst_n, o_out_valid, o_free_count <= FREE_W'(TX_SLOTS))
    // an accepted send rings the doorbell and closes its request
    `NDRE_ASSERT_NOW(a_send_bell, i_clk, i_rst_n, o_out_valid && (o_result_kind == KIND_SEND) && (o_status == ST_OK), o_doorbell && o_last)
    // a drained receive slot is never the closing word and never rings
    `NDRE_ASSERT_NOW(a_rx_word, i_clk, i_rst_n, o_out_valid && (o_result_kind == KIND_RX), !o_last && !o_doorbell && (o_status == ST_OK))
endmodule

// ===== verif/nic_descriptor_ring_engine_tb.sv =====
// Self-checking testbench for the descriptor ring engine: directed and random request words.
`timescale 1ns / 1ps
module nic_descriptor_ring_engine_tb;
    import ndre_pkg::*;

    localparam int TX_RING = TX_SLOTS_DEF;
    localparam int RX_RING = RX_SLOTS_DEF;
    localparam int IDLE_PCT = 34;

    // One request word as the block takes it.
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [LEN_W-1:0]  frame_length;
        logic [SLOT_W-1:0] slot_index;
        logic              tx_event;
        logic              rx_event;
    } t_ring_req;

    // One result word as the block returns it.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic              deliver;
        logic              eor;
        logic              bell;
        logic [FREE_W-1:0] free;
        logic              last;
    } t_ring_res;

    logic                i_clk;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_ready;
    logic [REQ_W-1:0]    i_req_type     = '0;
    logic [LEN_W-1:0]    i_frame_length = '0;
    logic [SLOT_W-1:0]   i_slot_index   = '0;
    logic                i_tx_event     = 1'b0;
    logic                i_rx_event     = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready    = 1'b0;
    logic [KIND_W-1:0]   o_result_kind;
    logic [STAT_W-1:0]   o_status;
    logic [SLOT_W-1:0]   o_ring_slot;
    logic [LEN_W-1:0]    o_slot_length;
    logic                o_deliver;
    logic                o_end_of_ring;
    logic                o_doorbell;
    logic [FREE_W-1:0]   o_free_count;
    logic                o_last;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    nic_descriptor_ring_engine u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_frame_length (i_frame_length),
        .i_slot_index   (i_slot_index),
        .i_tx_event     (i_tx_event),
        .i_rx_event     (i_rx_event),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_status       (o_status),
        .o_ring_slot    (o_ring_slot),
        .o_slot_length  (o_slot_length),
        .o_deliver      (o_deliver),
        .o_end_of_ring  (o_end_of_ring),
        .o_doorbell     (o_doorbell),
        .o_free_count   (o_free_count),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: register copies and ring ownership state.
    // ------------------------------------------------------------------
    logic              cfg_enabled;
    logic [LEN_W-1:0]  cfg_max_send;
    logic [LEN_W-1:0]  cfg_min_recv;
    logic [LEN_W-1:0]  cfg_buf_size;

    logic              tx_owned [TX_RING];
    logic              rx_owned [RX_RING];
    logic [LEN_W-1:0]  rx_len   [RX_RING];
    int unsigned       tx_next;
    int unsigned       tx_reap;
    int unsigned       tx_free;
    int unsigned       rx_next;

    // Words waiting to be offered, and result words still owed by the block.
    t_ring_req         request_q[$];
    t_ring_res         due_results[$];
    t_ring_req         offered_word;

    int unsigned       words_queued = 0;
    int unsigned       words_taken  = 0;
    int unsigned       counted      = 0;
    int unsigned       mismatches   = 0;

    // Set to drop all random idling on both sides for one phase.
    bit                calm         = 1'b0;
    // Long receiver hold-off, counted down in the receiving process.
    bit                hold_done    = 1'b0;
    int unsigned       hold_left    = 0;

    // Generator cursors: follow the rings roughly so that most releases and
    // fills land where the block will look for them next.
    int unsigned       gen_send_ptr;
    int unsigned       gen_rel_ptr;
    int unsigned       gen_fill_ptr;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("nic_descriptor_ring_engine: mismatch");
        $finish;
    end

    // Clear the shadow to its power-up state.
    task automatic clear_rings();
        cfg_enabled  = 1'b0;
        cfg_max_send = MAX_SEND_RST;
        cfg_min_recv = MIN_RECV_RST;
        cfg_buf_size = BUF_SIZE_RST;
        for (int i = 0; i < TX_RING; i++) tx_owned[i] = 1'b0;
        for (int i = 0; i < RX_RING; i++) begin
            rx_owned[i] = 1'b1;
            rx_len[i]   = '0;
        end
        tx_next  = 0;
        tx_reap  = 0;
        tx_free  = TX_RING;
        rx_next  = 0;
    endtask

    // Build one result word; the free count is always the current one.
    function automatic t_ring_res result_word(input int unsigned kind, status, slot, len,
                                              input bit deliver, eor, bell, last);
        t_ring_res r;
        r.kind    = KIND_W'(kind);
        r.status  = STAT_W'(status);
        r.slot    = SLOT_W'(slot);
        r.len     = LEN_W'(len);
        r.deliver = deliver;
        r.eor     = eor;
        r.bell    = bell;
        r.free    = FREE_W'(tx_free);
        r.last    = last;
        return r;
    endfunction

    // Advance the shadow by one accepted request word and queue the result
    // words it owes.
    function automatic void ring_outcome(input t_ring_req w);
        int unsigned n;
        logic [LEN_W-1:0] l;
        n = 0;
        case (w.req_type)
            REQ_SEND: begin
                // Checks run in a fixed order: enable, length, free slot.
                if (!cfg_enabled) begin
                    due_results.push_back(result_word(KIND_SEND, ST_INACTIVE, 0, 0, 0, 0, 0, 1));
                end else if (w.frame_length > cfg_max_send) begin
                    due_results.push_back(result_word(KIND_SEND, ST_TOO_LONG, 0, 0, 0, 0, 0, 1));
                end else if (tx_free == 0) begin
                    due_results.push_back(result_word(KIND_SEND, ST_FULL, 0, 0, 0, 0, 0, 1));
                end else begin
                    tx_owned[tx_next] = 1'b1;
                    tx_free--;
                    due_results.push_back(result_word(KIND_SEND, ST_OK, tx_next, w.frame_length,
                                                      0, tx_next == TX_RING - 1, 1, 1));
                    tx_next = (tx_next + 1 >= TX_RING) ? 0 : tx_next + 1;
                end
            end
            REQ_RELEASE: begin
                // Slots past the ring are dropped silently.
                if (w.slot_index < TX_RING) tx_owned[w.slot_index] = 1'b0;
            end
            REQ_FILL: begin
                if (w.slot_index < RX_RING) begin
                    rx_owned[w.slot_index] = 1'b0;
                    rx_len[w.slot_index]   = w.frame_length;
                end
            end
            default: begin
                // Reclaim in ring order, stopping at the first slot still
                // with the device or once every slot is free.
                if (w.tx_event) begin
                    while (tx_free < TX_RING && !tx_owned[tx_reap]) begin
                        tx_free++;
                        tx_reap = (tx_reap + 1 >= TX_RING) ? 0 : tx_reap + 1;
                    end
                end
                // Drain filled slots in order and re-arm each one.
                if (w.rx_event) begin
                    while (n < RX_RING && !rx_owned[rx_next]) begin
                        l = rx_len[rx_next];
                        due_results.push_back(result_word(KIND_RX, ST_OK, rx_next, l,
                                                          l >= cfg_min_recv && l <= cfg_buf_size,
                                                          rx_next == RX_RING - 1, 0, 0));
                        rx_len[rx_next]   = cfg_buf_size;
                        rx_owned[rx_next] = 1'b1;
                        rx_next = (rx_next + 1 >= RX_RING) ? 0 : rx_next + 1;
                        n++;
                    end
                end
                due_results.push_back(result_word(KIND_FIN, ST_OK, 0, 0, 0, 0, 0, 1));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer the next queued word, hold it until taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                ring_outcome(offered_word);
                words_taken++;
            end
            // Only change the payload once the current word has gone.
            if (!i_in_valid || o_in_ready) begin
                if (request_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    offered_word    = request_q.pop_front();
                    i_in_valid     <= 1'b1;
                    i_req_type     <= offered_word.req_type;
                    i_frame_length <= offered_word.frame_length;
                    i_slot_index   <= offered_word.slot_index;
                    i_tx_event     <= offered_word.tx_event;
                    i_rx_event     <= offered_word.rx_event;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input int unsigned want, got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: check each taken result word against the oldest one owed,
    // and throttle ready (random gaps, one long hold-off).
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_side
        t_ring_res want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t ns: result word with nothing owed, kind %0d",
                             $time, o_result_kind);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("result_kind", want.kind, o_result_kind);
                    check_field("status", want.status, o_status);
                    check_field("ring_slot", want.slot, o_ring_slot);
                    check_field("slot_length", want.len, o_slot_length);
                    check_field("deliver", want.deliver, o_deliver);
                    check_field("end_of_ring", want.eor, o_end_of_ring);
                    check_field("doorbell", want.bell, o_doorbell);
                    check_field("free_count", want.free, o_free_count);
                    check_field("last", want.last, o_last);
                end
            end
            // Hold off once while plenty of words are still queued, so the
            // result register and then the input side back up.
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && request_q.size() > 20) begin
                hold_done = 1'b1;
                hold_left = 400;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Register write over the configuration port; only called while idle.
    task automatic cfg_write(input logic [REGIDX_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLED:  cfg_enabled  = val[0];
            REG_MAX_SEND: cfg_max_send = val[LEN_W-1:0];
            REG_MIN_RECV: cfg_min_recv = val[LEN_W-1:0];
            default:      cfg_buf_size = val[LEN_W-1:0];
        endcase
    endtask

    // Queue one word; words the block simply drops do not count.
    task automatic add_word(input int unsigned req, len, slot, txe, rxe);
        t_ring_req w;
        w.req_type     = REQ_W'(req);
        w.frame_length = LEN_W'(len);
        w.slot_index   = SLOT_W'(slot);
        w.tx_event     = txe[0];
        w.rx_event     = rxe[0];
        request_q.push_back(w);
        words_queued++;
        if (!((w.req_type == REQ_RELEASE && w.slot_index >= TX_RING) ||
              (w.req_type == REQ_FILL && w.slot_index >= RX_RING)))
            counted++;
    endtask

    // Wait until every word is taken and every result word has come back,
    // then give a trailing release or fill time to finish.
    task automatic settle();
        while (words_taken != words_queued || due_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic int unsigned send_length();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 16383);
        return $urandom_range(0, cfg_max_send);
    endfunction

    // Fill lengths cluster on the deliver bounds, the rest spread wide.
    function automatic int unsigned fill_length();
        logic [LEN_W-1:0] l;
        case ($urandom_range(0, 5))
            0:       l = cfg_min_recv - 1'b1;
            1:       l = cfg_min_recv;
            2:       l = cfg_buf_size;
            3:       l = cfg_buf_size + 1'b1;
            default: l = LEN_W'($urandom_range(0, 16383));
        endcase
        return l;
    endfunction

    // One random sequence: mostly well-formed send/release/interrupt or
    // fill/interrupt runs, with some bare interrupts and noise.
    task automatic push_burst();
        int unsigned pick;
        int unsigned k;
        int unsigned l;
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
            k = $urandom_range(1, 5);
            for (int i = 0; i < k; i++) begin
                l = send_length();
                add_word(REQ_SEND, l, $urandom_range(0, 63), $urandom_range(0, 1),
                         $urandom_range(0, 1));
                if (cfg_enabled && l <= cfg_max_send) gen_send_ptr = (gen_send_ptr + 1) % TX_RING;
            end
            k = $urandom_range(0, 5);
            for (int i = 0; i < k && gen_rel_ptr != gen_send_ptr; i++) begin
                add_word(REQ_RELEASE, $urandom_range(0, 16383), gen_rel_ptr,
                         $urandom_range(0, 1), $urandom_range(0, 1));
                gen_rel_ptr = (gen_rel_ptr + 1) % TX_RING;
            end
            add_word(REQ_IRQ, $urandom_range(0, 16383), $urandom_range(0, 63), 1,
                     $urandom_range(0, 1));
        end else if (pick <= 6) begin
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++) begin
                add_word(REQ_FILL, fill_length(), gen_fill_ptr, $urandom_range(0, 1),
                         $urandom_range(0, 1));
                gen_fill_ptr = (gen_fill_ptr + 1) % RX_RING;
            end
            add_word(REQ_IRQ, $urandom_range(0, 16383), $urandom_range(0, 63),
                     $urandom_range(0, 1), 1);
        end else if (pick == 7) begin
            add_word(REQ_IRQ, $urandom_range(0, 16383), $urandom_range(0, 63),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        end else begin
            add_word($urandom_range(0, 3), $urandom_range(0, 16383), $urandom_range(0, 63),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int ph;
        int unsigned goal;
        clear_rings();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at their reset values: block disabled.
        add_word(REQ_SEND, 0, 0, 0, 0);              // refused, inactive
        add_word(REQ_FILL, 14, 0, 0, 0);             // exactly the minimum
        add_word(REQ_FILL, 13, 1, 0, 0);             // one short
        add_word(REQ_FILL, 2048, 2, 0, 0);           // exactly the buffer size
        add_word(REQ_FILL, 2049, 3, 0, 0);
        add_word(REQ_FILL, 16383, 3, 0, 0);          // overwrite a host-owned slot
        add_word(REQ_FILL, 100, 63, 0, 0);           // past the ring
        add_word(REQ_FILL, 100, RX_RING, 0, 0);      // first slot past the ring
        add_word(REQ_RELEASE, 0, 5, 0, 0);           // slot never sent
        add_word(REQ_RELEASE, 0, TX_RING, 1, 1);     // past the ring
        add_word(REQ_IRQ, 0, 0, 0, 1);               // drain slots 0 to 3
        add_word(REQ_IRQ, 0, 0, 1, 0);               // nothing to reclaim
        settle();

        // Widest limits.
        cfg_write(REG_ENABLED, 1);
        cfg_write(REG_MAX_SEND, 16383);
        cfg_write(REG_MIN_RECV, 0);
        cfg_write(REG_BUF_SIZE, 16383);
        add_word(REQ_SEND, 16383, 63, 1, 1);
        add_word(REQ_SEND, 0, 0, 0, 0);
        add_word(REQ_RELEASE, 0, 0, 0, 0);
        add_word(REQ_IRQ, 0, 0, 1, 0);               // reclaim stops at slot 1
        add_word(REQ_RELEASE, 0, 1, 0, 0);
        add_word(REQ_FILL, 0, 4, 0, 0);
        add_word(REQ_IRQ, 16383, 63, 1, 1);
        add_word(REQ_IRQ, 0, 0, 0, 0);               // closing word only
        settle();

        // Narrowest limits: nothing can be delivered.
        cfg_write(REG_MAX_SEND, 0);
        cfg_write(REG_MIN_RECV, 16383);
        cfg_write(REG_BUF_SIZE, 0);
        add_word(REQ_SEND, 1, 0, 0, 0);              // too long
        add_word(REQ_SEND, 0, 0, 0, 0);
        add_word(REQ_FILL, 16383, 5, 0, 0);
        add_word(REQ_FILL, 0, 6, 0, 0);
        add_word(REQ_IRQ, 0, 0, 1, 1);
        settle();

        // Pick the generator up where the directed words left the rings.
        gen_send_ptr = 3;
        gen_rel_ptr  = 2;
        gen_fill_ptr = 7;
        counted      = 0;

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    cfg_write(REG_MAX_SEND, 1518);
                    cfg_write(REG_MIN_RECV, 14);
                    cfg_write(REG_BUF_SIZE, 2048);
                end
                1: begin
                    cfg_write(REG_MAX_SEND, 16383);
                    cfg_write(REG_MIN_RECV, 0);
                    cfg_write(REG_BUF_SIZE, 16383);
                end
                2: cfg_write(REG_ENABLED, 0);
                3: begin
                    cfg_write(REG_ENABLED, 1);
                    cfg_write(REG_MAX_SEND, $urandom_range(0, 16383));
                    cfg_write(REG_MIN_RECV, $urandom_range(0, 100));
                    cfg_write(REG_BUF_SIZE, $urandom_range(1000, 16383));
                end
                default: begin
                    cfg_write(REG_MAX_SEND, $urandom_range(0, 16383));
                    cfg_write(REG_MIN_RECV, $urandom_range(0, 16383));
                    cfg_write(REG_BUF_SIZE, $urandom_range(0, 16383));
                end
            endcase
            calm = (ph == 3);
            if (ph == 0) begin
                // Overrun the transmit ring so sends come back full.
                for (int i = 0; i < TX_RING + 4; i++) begin
                    add_word(REQ_SEND, $urandom_range(0, 1518), $urandom_range(0, 63),
                             $urandom_range(0, 1), $urandom_range(0, 1));
                    gen_send_ptr = (gen_send_ptr + 1) % TX_RING;
                end
                add_word(REQ_IRQ, 0, 0, 1, 0);
            end
            if (ph == 1) begin
                // Fill the whole receive ring and drain it in one pass.
                for (int i = 0; i < RX_RING; i++) begin
                    add_word(REQ_FILL, fill_length(), gen_fill_ptr, 0, 0);
                    gen_fill_ptr = (gen_fill_ptr + 1) % RX_RING;
                end
                add_word(REQ_IRQ, $urandom_range(0, 16383), $urandom_range(0, 63), 1, 1);
            end
            goal = counted + 10;
            while (counted < goal) push_burst();
            settle();
        end
        calm = 1'b0;

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("nic_descriptor_ring_engine: match");
        end else begin
            $display("nic_descriptor_ring_engine: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ndre_pkg.sv
hdl/ndre_ram.sv
hdl/ndre_ctrl.sv
hdl/ndre_dp.sv
hdl/nic_descriptor_ring_engine.sv
verif/nic_descriptor_ring_engine_tb.sv
